>>> hw/rtl/mnpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mnpt_pkg;

    localparam int DELTA_W    = 28;
    localparam int CMD_W      = 2;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int CHAN_W     = 4;
    localparam int OUT_TICK_W = 48;
    localparam int CFG_IDX_W  = 1;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 120;

    localparam logic [CMD_W-1:0] CMD_OTHER    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_NOTE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_NOTE = 1'd1;

    localparam logic [NOTE_W-1:0] LOWEST_RESET  = 7'd0;
    localparam logic [NOTE_W-1:0] HIGHEST_RESET = 7'd127;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic out_blocked;
    } dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/midi_note_pairing_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Pairs MIDI note-on and note-off events into finished notes measured in ticks.
// Each event advances a tick clock (saturating at its top value) by its delta time;
// note events within [lowest_note, highest_note] look up the slot of that note, and
// an open slot yields one result (slot, start tick, duration, velocity, channel)
// before a note-on with nonzero velocity reopens it. Each event is handled in a load
// step that reads the slot record memory and a lookup step that updates it, and no
// new event is taken until it is done; an event that finishes a note stays in its
// lookup step while the previous result still sits unaccepted in the output
// register. Open flags are all cleared by reset; no clearing pass is needed.
module midi_note_pairing_tracker
    import mnpt_pkg::*;
#(
    parameter int NOTE_SLOTS = 128,
    parameter int TICK_BITS  = 48
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [NOTE_W-1:0]    cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // delta_ticks, note_number, velocity, channel, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  wire logic [CMD_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // note_slot, start_tick, duration_ticks, note_velocity, note_channel, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    mnpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    mnpt_dpath #(
        .NOTE_SLOTS (NOTE_SLOTS),
        .TICK_BITS  (TICK_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted during lookup");

    a_result_follows_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised outside lookup");

    a_slot_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[NOTE_W-1:0]} < (NOTE_W + 1)'(NOTE_SLOTS)))
        else $error("result slot beyond table");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/mnpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mnpt_ctrl
    import mnpt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // hold while a finished note still waits in the result register
                if (!(status.hit && status.out_blocked)) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/mnpt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module mnpt_dpath
    import mnpt_pkg::*;
#(
    parameter int NOTE_SLOTS = 128,
    parameter int TICK_BITS  = 48
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [NOTE_W-1:0]    cfg_data,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [CMD_W-1:0]     s_tuser,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int SLOT_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int REC_W  = TICK_BITS + VEL_W + CHAN_W;
    localparam logic [NOTE_W:0] SLOT_LIMIT = (NOTE_W + 1)'(NOTE_SLOTS);

    logic [NOTE_W-1:0] lowest_reg;
    logic [NOTE_W-1:0] highest_reg;

    logic [DELTA_W-1:0] in_delta;
    logic [NOTE_W-1:0]  in_note;
    logic [VEL_W-1:0]   in_vel;
    logic [CHAN_W-1:0]  in_chan;
    logic [NOTE_W-1:0]  in_slot;
    logic               in_hit_range;
    logic               in_note_cmd;

    logic [TICK_BITS:0]   clock_sum;
    logic [TICK_BITS-1:0] clock_next;
    logic [TICK_BITS-1:0] clock_reg;

    logic                 item_valid_reg;
    logic                 note_on_reg;
    logic [NOTE_W-1:0]    slot_reg;
    logic [VEL_W-1:0]     vel_reg;
    logic [CHAN_W-1:0]    chan_reg;
    logic [SLOT_W-1:0]    slot_idx;

    logic [NOTE_SLOTS-1:0] open_reg;
    logic [REC_W-1:0]      rec_mem [NOTE_SLOTS];
    logic [REC_W-1:0]      rd_data_reg;

    logic [TICK_BITS-1:0]        rd_start;
    logic [VEL_W-1:0]            rd_vel;
    logic [CHAN_W-1:0]           rd_chan;
    logic [TICK_BITS-1:0]        duration;
    logic [TICK_BITS+OUT_TICK_W-1:0] start_wide;
    logic [TICK_BITS+OUT_TICK_W-1:0] dur_wide;

    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_reg  <= LOWEST_RESET;
            highest_reg <= HIGHEST_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LOWEST_NOTE:  lowest_reg  <= cfg_data;
                CFG_HIGHEST_NOTE: highest_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request decode
    assign in_delta = s_tdata[DELTA_W-1:0];
    assign in_note  = s_tdata[DELTA_W +: NOTE_W];
    assign in_vel   = s_tdata[DELTA_W+NOTE_W +: VEL_W];
    assign in_chan  = s_tdata[DELTA_W+NOTE_W+VEL_W +: CHAN_W];
    assign in_slot  = in_note - lowest_reg;

    assign in_note_cmd  = (s_tuser == CMD_NOTE_OFF) || (s_tuser == CMD_NOTE_ON);
    assign in_hit_range = in_note_cmd && (in_note >= lowest_reg) && (in_note <= highest_reg)
                          && ({1'b0, in_slot} < SLOT_LIMIT);

    // saturating tick clock
    assign clock_sum  = {1'b0, clock_reg} + (TICK_BITS + 1)'(in_delta);
    assign clock_next = clock_sum[TICK_BITS] ? '1 : clock_sum[TICK_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg      <= '0;
            item_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            clock_reg      <= clock_next;
            item_valid_reg <= in_hit_range;
        end else if (cmd.commit) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            note_on_reg <= (s_tuser == CMD_NOTE_ON) && (in_vel != '0);
            slot_reg    <= in_slot;
            vel_reg     <= in_vel;
            chan_reg    <= in_chan;
        end
    end

    assign slot_idx = slot_reg[SLOT_W-1:0];

    // slot record memory: read on load, write on commit of an in-range note-on with nonzero velocity
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_data_reg <= rec_mem[in_slot[SLOT_W-1:0]];
        end
        if (cmd.commit && item_valid_reg && note_on_reg) begin
            rec_mem[slot_idx] <= {clock_reg, vel_reg, chan_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else if (cmd.commit && item_valid_reg) begin
            open_reg[slot_idx] <= note_on_reg;
        end
    end

    assign rd_start = rd_data_reg[VEL_W+CHAN_W +: TICK_BITS];
    assign rd_vel   = rd_data_reg[CHAN_W +: VEL_W];
    assign rd_chan  = rd_data_reg[CHAN_W-1:0];
    assign duration = clock_reg - rd_start;

    assign start_wide = {{OUT_TICK_W{1'b0}}, rd_start};
    assign dur_wide   = {{OUT_TICK_W{1'b0}}, duration};

    assign status = '{hit: item_valid_reg && open_reg[slot_idx],
                      out_blocked: out_valid_reg && !m_tready};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit && status.hit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && status.hit) begin
            out_data_reg <= {6'd0, rd_chan, rd_vel, dur_wide[OUT_TICK_W-1:0],
                             start_wide[OUT_TICK_W-1:0], slot_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
